// File: src/antialiased_line_char_raster_core_assert.svh
// assertion macros for the line raster core
`ifndef ANTIALIASED_LINE_CHAR_RASTER_CORE_ASSERT_SVH
`define ANTIALIASED_LINE_CHAR_RASTER_CORE_ASSERT_SVH

// same-cycle implication, held off while reset is low
`define ALCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while reset is low
`define ALCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/alcr_pkg.sv
`timescale 1ns / 1ps
package alcr_pkg;

    localparam int DEF_FRAME_ROWS = 25;
    localparam int DEF_FRAME_COLS = 80;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int KIND_W  = 2;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 7;
    localparam int COV_MAX = 25;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 7'd32;
    localparam logic [CHAR_W-1:0] FULL_CHAR  = 7'd64;
    localparam logic [CHAR_W-1:0] TOP_CHAR   = 7'd37;

    typedef enum logic [KIND_W-1:0] {
        KIND_CLEAR = 2'd0,
        KIND_DRAW  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef logic [CHAR_W-1:0] t_char_tab [10];
    localparam t_char_tab TENTH_CHARS = '{
        7'd32, 7'd46, 7'd95, 7'd58, 7'd45, 7'd61, 7'd43, 7'd42, 7'd110, 7'd35
    };

    typedef struct packed {
        logic load;
        logic clr_step;
        logic div_step;
        logic wr_a;
        logic wr_b;
        logic advance;
        logic rd;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic last_major;
        logic out_free;
    } t_status;

    // coverage c against one = 2^fb, quantised in tenths
    function automatic logic [CHAR_W-1:0] cov_char(input logic [COV_MAX-1:0] c,
                                                   input int fb);
        logic [COV_MAX+4:0] one;
        logic [COV_MAX+4:0] c10;
        logic [CHAR_W-1:0]  ch;
        one = (COV_MAX+5)'(1) << fb;
        c10 = (COV_MAX+5)'(c) * (COV_MAX+5)'(10);
        ch  = TOP_CHAR;
        for (int k = 9; k >= 1; k--) begin
            if (c10 <= (COV_MAX+5)'(k) * one) begin
                ch = TENTH_CHARS[k];
            end
        end
        if (c == '0) begin
            ch = SPACE_CHAR;
        end else if ((COV_MAX+5)'(c) >= one) begin
            ch = FULL_CHAR;
        end
        return ch;
    endfunction

endpackage

// File: src/alcr_ctrl.sv
`timescale 1ns / 1ps
module alcr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [1:0]       i_kind,
    input  alcr_pkg::t_status i_status,
    output logic             o_in_ready,
    output alcr_pkg::t_cmd   o_cmd
);
    import alcr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLR    = 7'b0000010,
        S_DIV    = 7'b0000100,
        S_STEP_A = 7'b0001000,
        S_STEP_B = 7'b0010000,
        S_RD_MEM = 7'b0100000,
        S_RD_OUT = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;   // frame is swept to spaces after reset
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (t_kind'(i_kind))
                        KIND_CLEAR: n_state = S_CLR;
                        KIND_DRAW:  n_state = S_DIV;
                        KIND_READ:  n_state = S_RD_MEM;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_STEP_A;
            end
            S_STEP_A: begin
                o_cmd.wr_a = 1'b1;
                n_state    = S_STEP_B;
            end
            S_STEP_B: begin
                o_cmd.wr_b    = 1'b1;
                o_cmd.advance = 1'b1;
                n_state = i_status.last_major ? S_IDLE : S_STEP_A;
            end
            S_RD_MEM: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RD_OUT;
            end
            S_RD_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// File: src/alcr_datapath.sv
`timescale 1ns / 1ps
module alcr_datapath #(
    parameter int FRAME_ROWS = alcr_pkg::DEF_FRAME_ROWS,
    parameter int FRAME_COLS = alcr_pkg::DEF_FRAME_COLS,
    parameter int FRAC_BITS  = alcr_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  alcr_pkg::t_cmd              i_cmd,
    input  logic [alcr_pkg::COL_W-1:0]  i_start_col,
    input  logic [alcr_pkg::ROW_W-1:0]  i_start_row,
    input  logic [alcr_pkg::COL_W-1:0]  i_end_col,
    input  logic [alcr_pkg::ROW_W-1:0]  i_end_row,
    input  logic [alcr_pkg::ROW_W-1:0]  i_probe_row,
    input  logic [alcr_pkg::COL_W-1:0]  i_probe_col,
    input  logic                        i_out_ready,
    output alcr_pkg::t_status           o_status,
    output logic                        o_out_valid,
    output logic [alcr_pkg::CHAR_W-1:0] o_cell_char
);
    import alcr_pkg::*;

    localparam int RB     = $clog2(FRAME_ROWS);
    localparam int CB     = $clog2(FRAME_COLS);
    localparam int AW     = RB + CB;
    localparam int DEPTH  = 1 << AW;
    localparam int DVD_W  = COL_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(DVD_W);
    localparam int ACC_W  = FRAC_BITS + 9;

    // frame memory
    logic [CHAR_W-1:0] r_mem [DEPTH];
    logic [CHAR_W-1:0] r_rdata;

    // draw state
    logic [COL_W-1:0]       r_major, r_major_end, r_d;
    logic                   r_steep, r_neg;
    logic [ACC_W-1:0]       r_acc;
    logic [7:0]             r_rem;
    logic [DVD_W-1:0]       r_dvd;
    logic [FRAC_BITS:0]     r_quot;
    logic [CNT_W-1:0]       r_div_cnt;
    logic [AW-1:0]          r_clr_addr;
    logic [ROW_W-1:0]       r_probe_row;
    logic [COL_W-1:0]       r_probe_col;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_cell_char;

    // endpoint setup
    logic [COL_W-1:0] adc, adr, ms, me, ns, ne, msa, mea, nsa, nea, ae;
    logic             steep, swap, neg;

    always_comb begin
        adc   = (i_end_col >= i_start_col) ? i_end_col - i_start_col
                                           : i_start_col - i_end_col;
        adr   = (i_end_row >= i_start_row) ? COL_W'(i_end_row - i_start_row)
                                           : COL_W'(i_start_row - i_end_row);
        steep = adr > adc;
        msa   = steep ? COL_W'(i_start_row) : i_start_col;
        mea   = steep ? COL_W'(i_end_row)   : i_end_col;
        nsa   = steep ? i_start_col : COL_W'(i_start_row);
        nea   = steep ? i_end_col   : COL_W'(i_end_row);
        swap  = msa > mea;
        ms    = swap ? mea : msa;
        me    = swap ? msa : mea;
        ns    = swap ? nea : nsa;
        ne    = swap ? nsa : nea;
        neg   = ne < ns;
        ae    = neg ? ns - ne : ne - ns;
    end

    // restoring divider, one quotient bit a cycle
    logic [7:0] rem_sh;
    logic       ge;
    assign rem_sh = {r_rem[6:0], r_dvd[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, r_d};

    // current step cells
    logic [7:0]           fl;
    logic [FRAC_BITS-1:0] frac;
    logic [FRAC_BITS:0]   cov_a, cov_b, cov;
    logic [8:0]           minor, row, col;
    logic                 in_frame, wr_en;
    logic [AW-1:0]        wr_addr;
    logic [CHAR_W-1:0]    wr_data;

    always_comb begin
        fl    = r_acc[FRAC_BITS+7:FRAC_BITS];
        frac  = r_acc[FRAC_BITS-1:0];
        cov_a = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac};
        cov_b = {1'b0, frac};
        cov   = i_cmd.wr_b ? cov_b : cov_a;
        minor = i_cmd.wr_b ? {1'b0, fl} + 9'd1 : {1'b0, fl};
        row   = r_steep ? {2'b0, r_major} : minor;
        col   = r_steep ? minor : {2'b0, r_major};
        in_frame = (row < 9'(FRAME_ROWS)) && (col < 9'(FRAME_COLS));
        if (i_cmd.clr_step) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = SPACE_CHAR;
        end else begin
            wr_en   = (i_cmd.wr_a || i_cmd.wr_b) && in_frame;
            wr_addr = {row[RB-1:0], col[CB-1:0]};
            wr_data = cov_char(COV_MAX'(cov), FRAC_BITS);
        end
    end

    logic probe_in;
    assign probe_in = ({1'b0, r_probe_row} < (ROW_W+1)'(FRAME_ROWS)) &&
                      (8'(r_probe_col) < 8'(FRAME_COLS));

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (i_cmd.rd) r_rdata <= r_mem[{r_probe_row[RB-1:0], r_probe_col[CB-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_steep     <= steep;
            r_neg       <= neg;
            r_major     <= ms;
            r_major_end <= me;
            r_d         <= me - ms;
            r_acc       <= ACC_W'({ns, {FRAC_BITS{1'b0}}});
            r_rem       <= '0;
            r_dvd       <= {ae, {FRAC_BITS{1'b0}}};
            r_quot      <= '0;
            r_div_cnt   <= '0;
            r_probe_row <= i_probe_row;
            r_probe_col <= i_probe_col;
        end
        if (i_cmd.div_step) begin
            r_rem     <= ge ? rem_sh - {1'b0, r_d} : rem_sh;
            r_dvd     <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quot    <= {r_quot[FRAC_BITS-1:0], ge};
            r_div_cnt <= r_div_cnt + CNT_W'(1);
        end
        if (i_cmd.advance) begin
            r_acc   <= r_neg ? r_acc - ACC_W'(r_quot) : r_acc + ACC_W'(r_quot);
            r_major <= r_major + COL_W'(1);
        end
        if (i_cmd.out_load) begin
            r_cell_char <= probe_in ? r_rdata : SPACE_CHAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) r_clr_addr <= '0;
            else if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + AW'(1);
            if (i_cmd.out_load) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    assign o_status.clr_last   = (r_clr_addr == AW'(DEPTH - 1));
    assign o_status.div_last   = (r_div_cnt == CNT_W'(DVD_W - 1));
    assign o_status.last_major = (r_major == r_major_end);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_cell_char = r_cell_char;

endmodule

// File: src/antialiased_line_char_raster_core.sv
`timescale 1ns / 1ps
// Antialiased line raster into a FRAME_ROWS x FRAME_COLS character frame held in one
// on-chip memory of 2^(clog2(rows)+clog2(cols)) entries. A clear request sweeps that memory,
// one entry a cycle (4096 entries at 25 x 80), and the same sweep runs after reset, during
// which no request is taken. A draw request runs the bit-serial slope divider over the
// 7+FRAC_BITS dividend bits, then writes two cells per major-axis step (one memory write
// each). A read request reads the memory, then loads the output register once it is free,
// returning one character; the next request may be taken while it waits at the output.
module antialiased_line_char_raster_core #(
    parameter int FRAME_ROWS = alcr_pkg::DEF_FRAME_ROWS,
    parameter int FRAME_COLS = alcr_pkg::DEF_FRAME_COLS,
    parameter int FRAC_BITS  = alcr_pkg::DEF_FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [alcr_pkg::KIND_W-1:0] i_kind,
    input  logic [alcr_pkg::COL_W-1:0]  i_start_col,
    input  logic [alcr_pkg::ROW_W-1:0]  i_start_row,
    input  logic [alcr_pkg::COL_W-1:0]  i_end_col,
    input  logic [alcr_pkg::ROW_W-1:0]  i_end_row,
    input  logic [alcr_pkg::ROW_W-1:0]  i_probe_row,
    input  logic [alcr_pkg::COL_W-1:0]  i_probe_col,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [alcr_pkg::CHAR_W-1:0] o_cell_char
);
    import alcr_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    alcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    alcr_datapath #(
        .FRAME_ROWS (FRAME_ROWS),
        .FRAME_COLS (FRAME_COLS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_start_col (i_start_col),
        .i_start_row (i_start_row),
        .i_end_col   (i_end_col),
        .i_end_row   (i_end_row),
        .i_probe_row (i_probe_row),
        .i_probe_col (i_probe_col),
        .i_out_ready (i_out_ready),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .o_cell_char (o_cell_char)
    );

`include "antialiased_line_char_raster_core_assert.svh"

    `ALCR_ASSERT_NEXT(a_busy_after_draw, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_kind == KIND_DRAW || i_kind == KIND_CLEAR), !o_in_ready, "request taken during draw or clear")
    `ALCR_ASSERT_NOW(a_no_write_idle, i_clk, i_rst_n, w_cmd.wr_a || w_cmd.wr_b || w_cmd.clr_step, !o_in_ready, "frame write while idle")
    `ALCR_ASSERT_NOW(a_out_load_free, i_clk, i_rst_n, w_cmd.out_load, !o_out_valid || i_out_ready, "result overwritten before taken")

endmodule
